// ===== rtl/rfe_pkg.sv =====
// Shared types, fixed-point constants and the CORDIC arctangent table
// for the Euler-angle rotation matrix pipeline. No dependencies.
`default_nettype none
package rfe_pkg;

    localparam int ANG_W  = 15;   // input angle width, degrees * 64
    localparam int CW     = 34;   // CORDIC and Q4.30 datapath width, sign included
    localparam int PW     = 68;   // Q60 product and sum width
    localparam int IFRAC  = 30;   // fraction bits of the internal format

    typedef logic signed [ANG_W-1:0] t_angle;
    typedef logic signed [CW-1:0]    t_cval;
    typedef logic signed [PW-1:0]    t_prod;

    // degrees*64 to binary angle: |a|*2^23/45 = |a|*186413 + (|a|*23 + 22)/45
    localparam logic [17:0] MAG_MUL  = 18'd186413;
    localparam logic [4:0]  REM_MUL  = 5'd23;
    localparam logic [4:0]  REM_ADD  = 5'd22;
    localparam int          REM_W    = 19;
    // floor(v/45) = (v * RECIP) >> RECIP_SH, exact for v < 2^19
    localparam logic [19:0] RECIP    = 20'd745655;
    localparam int          RECIP_SH = 25;

    localparam t_cval INV_GAIN = t_cval'(34'h026DD3B6A);
    localparam t_cval QTR_TURN = t_cval'(34'h040000000);
    localparam t_cval HALF_TURN = t_cval'(34'h080000000);

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;  5'd31: v = 32'h00000000;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Q30 x Q30 -> Q60
    function automatic t_prod mulp(input t_cval a, input t_cval b);
        return a * b;
    endfunction

    // Q60 -> Q30, round half up
    function automatic t_cval rnd30(input t_prod p);
        t_prod q;
        q = (p + (t_prod'(1) <<< (IFRAC - 1))) >>> IFRAC;
        return q[CW-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rfe_angle.sv =====
// Three-stage conversion of three degree*64 angles to folded binary angles.
// Depends on rfe_pkg.
`default_nettype none
module rfe_angle (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire rfe_pkg::t_angle i_ang [3],
    output logic               o_valid,
    output rfe_pkg::t_cval     o_z [3],
    output logic [2:0]         o_neg
);
    logic [14:0]                   n_mag [3];
    logic [31:0]                   r_hi  [3];
    logic [rfe_pkg::REM_W-1:0]     r_rem [3];
    logic [2:0]                    r_sgn;
    logic [31:0]                   r_t   [3];
    logic                          r_v1, r_v2, r_v3;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_mag[l] = i_ang[l][14] ? 15'(~i_ang[l] + 15'd1) : 15'(i_ang[l]);
        end
    end

    // stage 1: split |a|*2^23/45 into an exact whole part and a small remainder
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_hi[l]  <= 32'(33'(n_mag[l]) * 33'(rfe_pkg::MAG_MUL));
                r_rem[l] <= rfe_pkg::REM_W'(n_mag[l]) * rfe_pkg::REM_W'(rfe_pkg::REM_MUL)
                            + rfe_pkg::REM_W'(rfe_pkg::REM_ADD);
                r_sgn[l] <= i_ang[l][14];
            end
        end
    end

    // stage 2: divide the remainder by 45, restore the sign
    always_ff @(posedge i_clk) begin
        logic [31:0] q;
        logic [38:0] pr;
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                pr = 39'(r_rem[l]) * 39'(rfe_pkg::RECIP);
                q  = r_hi[l] + 32'(pr >> rfe_pkg::RECIP_SH);
                r_t[l] <= r_sgn[l] ? 32'(32'd0 - q) : q;
            end
        end
    end

    // stage 3: fold into plus or minus a quarter turn
    always_ff @(posedge i_clk) begin
        rfe_pkg::t_cval zz;
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                zz = {{2{r_t[l][31]}}, r_t[l]};
                if (zz > rfe_pkg::QTR_TURN) begin
                    o_z[l]   <= zz - rfe_pkg::HALF_TURN;
                    o_neg[l] <= 1'b1;
                end else if (zz < -rfe_pkg::QTR_TURN) begin
                    o_z[l]   <= zz + rfe_pkg::HALF_TURN;
                    o_neg[l] <= 1'b1;
                end else begin
                    o_z[l]   <= zz;
                    o_neg[l] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_valid = r_v3;

endmodule
`default_nettype wire

// ===== rtl/rfe_cordic.sv =====
// Unrolled rotation-mode CORDIC, one register stage per step, three lanes,
// plus a final sign-restore stage. Depends on rfe_pkg.
`default_nettype none
module rfe_cordic #(
    parameter int STEPS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire rfe_pkg::t_cval i_z [3],
    input  wire logic [2:0]    i_neg,
    output logic               o_valid,
    output rfe_pkg::t_cval     o_cos [3],
    output rfe_pkg::t_cval     o_sin [3]
);
    rfe_pkg::t_cval w_x [STEPS+1][3];
    rfe_pkg::t_cval w_y [STEPS+1][3];
    rfe_pkg::t_cval w_z [STEPS+1][3];
    logic [2:0]     w_n [STEPS+1];
    logic           w_v [STEPS+1];
    logic           r_vo;

    for (genvar l = 0; l < 3; l++) begin : g_init
        assign w_x[0][l] = rfe_pkg::INV_GAIN;
        assign w_y[0][l] = '0;
        assign w_z[0][l] = i_z[l];
    end
    assign w_n[0] = i_neg;
    assign w_v[0] = i_valid;

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        logic [2:0] r_n;
        logic       r_v;
        for (genvar l = 0; l < 3; l++) begin : g_lane
            rfe_pkg::t_cval dx, dy, da, r_x, r_y, r_z;
            assign dx = w_y[s][l] >>> s;
            assign dy = w_x[s][l] >>> s;
            assign da = {2'b00, rfe_pkg::atan_turn(5'(s))};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!w_z[s][l][rfe_pkg::CW-1]) begin
                        r_x <= w_x[s][l] - dx;
                        r_y <= w_y[s][l] + dy;
                        r_z <= w_z[s][l] - da;
                    end else begin
                        r_x <= w_x[s][l] + dx;
                        r_y <= w_y[s][l] - dy;
                        r_z <= w_z[s][l] + da;
                    end
                end
            end
            assign w_x[s+1][l] = r_x;
            assign w_y[s+1][l] = r_y;
            assign w_z[s+1][l] = r_z;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n <= w_n[s];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[s];
            end
        end
        assign w_n[s+1] = r_n;
        assign w_v[s+1] = r_v;
    end

    // negate both results where the angle was folded by half a turn
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                o_cos[l] <= w_n[STEPS][l] ? -w_x[STEPS][l] : w_x[STEPS][l];
                o_sin[l] <= w_n[STEPS][l] ? -w_y[STEPS][l] : w_y[STEPS][l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= w_v[STEPS];
        end
    end

    assign o_valid = r_vo;

endmodule
`default_nettype wire

// ===== rtl/rfe_matrix.sv =====
// Four-stage product, sum and rounding pipeline for the nine matrix entries.
// Depends on rfe_pkg.
`default_nettype none
module rfe_matrix #(
    parameter int FRAC = 14
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire rfe_pkg::t_cval i_cos [3],
    input  wire rfe_pkg::t_cval i_sin [3],
    output logic               o_valid,
    output logic [FRAC+1:0]    o_r [9]
);
    localparam int SH = 2 * rfe_pkg::IFRAC - FRAC;
    localparam rfe_pkg::t_prod HALF = rfe_pkg::t_prod'(1) <<< (SH - 1);
    localparam rfe_pkg::t_prod ONE  = rfe_pkg::t_prod'(1) <<< FRAC;

    rfe_pkg::t_prod r_d  [9];
    rfe_pkg::t_prod r_d2 [9];
    rfe_pkg::t_prod r_t  [4];
    rfe_pkg::t_prod r_m  [9];
    rfe_pkg::t_cval r_azy, r_asy, r_sx, r_cx;
    logic           r_v1, r_v2, r_v3, r_v4;

    // stage 1: two-term products, first pair of each three-term product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0] <= rfe_pkg::mulp(i_cos[2], i_cos[1]);
            r_d[1] <= rfe_pkg::mulp(i_sin[2], i_cos[0]);
            r_d[2] <= rfe_pkg::mulp(i_sin[2], i_sin[0]);
            r_d[3] <= rfe_pkg::mulp(i_sin[2], i_cos[1]);
            r_d[4] <= rfe_pkg::mulp(i_cos[2], i_cos[0]);
            r_d[5] <= rfe_pkg::mulp(i_cos[2], i_sin[0]);
            r_d[6] <= -(rfe_pkg::t_prod'(i_sin[1]) <<< rfe_pkg::IFRAC);
            r_d[7] <= rfe_pkg::mulp(i_cos[1], i_sin[0]);
            r_d[8] <= rfe_pkg::mulp(i_cos[1], i_cos[0]);
            r_azy  <= rfe_pkg::rnd30(rfe_pkg::mulp(i_cos[2], i_sin[1]));
            r_asy  <= rfe_pkg::rnd30(rfe_pkg::mulp(i_sin[2], i_sin[1]));
            r_sx   <= i_sin[0];
            r_cx   <= i_cos[0];
        end
    end

    // stage 2: third factor of the three-term products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d2   <= r_d;
            r_t[0] <= rfe_pkg::mulp(r_azy, r_sx);
            r_t[1] <= rfe_pkg::mulp(r_azy, r_cx);
            r_t[2] <= rfe_pkg::mulp(r_asy, r_sx);
            r_t[3] <= rfe_pkg::mulp(r_asy, r_cx);
        end
    end

    // stage 3: exact sums in Q60
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= r_d2[0];
            r_m[1] <= r_t[0] - r_d2[1];
            r_m[2] <= r_t[1] + r_d2[2];
            r_m[3] <= r_d2[3];
            r_m[4] <= r_t[2] + r_d2[4];
            r_m[5] <= r_t[3] - r_d2[5];
            r_m[6] <= r_d2[6];
            r_m[7] <= r_d2[7];
            r_m[8] <= r_d2[8];
        end
    end

    // stage 4: round half up, saturate to plus or minus one
    always_ff @(posedge i_clk) begin
        rfe_pkg::t_prod q;
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                q = (r_m[k] + HALF) >>> SH;
                if (q > ONE) begin
                    q = ONE;
                end else if (q < -ONE) begin
                    q = -ONE;
                end
                o_r[k] <= q[FRAC+1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_valid = r_v4;

endmodule
`default_nettype wire

// ===== rtl/rotation_from_euler_angles.sv =====
// Top level: Z-Y-X Euler angles to a 3x3 rotation matrix, fully pipelined.
// Depends on rfe_pkg, rfe_angle, rfe_cordic and rfe_matrix.
//
//  channel   dir  handshake                          payload
//  s_axis    in   i_s_axis_tvalid / o_s_axis_tready   angle_x, angle_y, angle_z
//  m_axis    out  o_m_axis_tvalid / i_m_axis_tready   r00 .. r22
//
// One item enters per cycle while the skid register is free; each passes
// through 3 angle stages, CORDIC_STEPS CORDIC steps, 1 sign stage, 4 matrix
// stages and 1 output register. The unrolled CORDIC sets the depth.
// Reset is synchronous, active low, and clears only the valid bits.
// A skid register behind the output register takes one more item while the
// output stalls; the whole pipeline then holds until the skid drains.
`default_nettype none
module rotation_from_euler_angles #(
    parameter int OUT_FRAC_BITS = 14,
    parameter int CORDIC_STEPS  = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // [14:0] angle_x, [29:15] angle_y, [44:30] angle_z, [47:45] zero
    input  wire logic [47:0]          i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // r00, r01, r02, r10, r11, r12, r20, r21, r22, each OUT_FRAC_BITS+2 wide,
    // from the lowest bit up, zero fill to whole bytes
    output logic [((9*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] o_m_axis_tdata
);
    localparam int W   = OUT_FRAC_BITS + 2;
    localparam int OW  = 9 * W;
    localparam int TDW = ((OW + 7) / 8) * 8;

    logic            en;
    rfe_pkg::t_angle ang [3];
    rfe_pkg::t_cval  z [3];
    logic [2:0]      neg;
    logic            ang_v, cs_v, mat_v;
    rfe_pkg::t_cval  cs_c [3];
    rfe_pkg::t_cval  cs_s [3];
    logic [W-1:0]    mat_r [9];
    logic [OW-1:0]   mat_pk;
    logic [OW-1:0]   r_o, r_sk;
    logic            r_o_valid, r_sk_valid;

    // the pipeline advances whenever the skid register is free
    assign en              = !r_sk_valid;
    assign o_s_axis_tready = en;

    assign ang[0] = i_s_axis_tdata[14:0];
    assign ang[1] = i_s_axis_tdata[29:15];
    assign ang[2] = i_s_axis_tdata[44:30];

    rfe_angle u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_ang   (ang),
        .o_valid (ang_v),
        .o_z     (z),
        .o_neg   (neg)
    );

    rfe_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ang_v),
        .i_z     (z),
        .i_neg   (neg),
        .o_valid (cs_v),
        .o_cos   (cs_c),
        .o_sin   (cs_s)
    );

    rfe_matrix #(.FRAC(OUT_FRAC_BITS)) u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cs_v),
        .i_cos   (cs_c),
        .i_sin   (cs_s),
        .o_valid (mat_v),
        .o_r     (mat_r)
    );

    for (genvar k = 0; k < 9; k++) begin : g_pack
        assign mat_pk[k*W +: W] = mat_r[k];
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid  <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (r_sk_valid) begin
            if (i_m_axis_tready) begin
                r_o        <= r_sk;
                r_sk_valid <= 1'b0;
            end
        end else if (mat_v) begin
            if (!r_o_valid || i_m_axis_tready) begin
                r_o       <= mat_pk;
                r_o_valid <= 1'b1;
            end else begin
                r_sk       <= mat_pk;
                r_sk_valid <= 1'b1;
            end
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = TDW'(r_o);

endmodule
`default_nettype wire

// ===== rtl/rfe_check.sv =====
// Port-level checks for rotation_from_euler_angles, bound to the top level.
// Depends on rotation_from_euler_angles.
`default_nettype none
module rfe_check #(
    parameter int DW = 144
) (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_s_axis_tready,
    input wire logic          o_m_axis_tvalid,
    input wire logic          i_m_axis_tready,
    input wire logic [DW-1:0] o_m_axis_tdata
);
    // reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // input back-pressure only while a result is on offer
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with no result waiting");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind rotation_from_euler_angles rfe_check #(.DW($bits(o_m_axis_tdata))) u_rfe_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire
